@@ rtl/core/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Types, constants and helpers shared by the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = $clog2(MaxPayload + 1);
  localparam int unsigned PosW       = 6;

  localparam logic [ByteW-1:0] StartByte = 8'h21;
  localparam logic [ByteW-1:0] MaxLen    = ByteW'(MaxPayload);

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_OK     = 3'd1,
    KIND_BADSUM = 3'd2,
    KIND_BADLEN = 3'd3,
    KIND_BADCMD = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_CMD   = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] value;
    logic [PosW-1:0]  position;
    logic             frame_end;
  } result_t;

  function automatic logic known_command(input logic [ByteW-1:0] c);
    return (c == 8'h56) || (c == 8'h43) || (c == 8'h47) || (c == 8'h53) ||
           (c == 8'h49) || (c == 8'h48) || (c == 8'h4D);
  endfunction

endpackage

@@ rtl/core/cfr_if.sv @@
// ----------------------------------------------------------------------------
// cfr_byte_if / cfr_result_if
// Valid/ready channels for received bytes and receiver results.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] command;
  logic [7:0] value;
  logic [5:0] position;
  logic       frame_end;

  modport source (output valid, output kind, output command, output value,
                  output position, output frame_end, input ready);
  modport sink   (input valid, input kind, input command, input value,
                  input position, input frame_end, output ready);
endinterface

@@ rtl/core/cfr_in_reg.sv @@
// ----------------------------------------------------------------------------
// cfr_in_reg
// Input register stage for received bytes.
// ----------------------------------------------------------------------------
module cfr_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [cfr_pkg::ByteW-1:0] byte_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [cfr_pkg::ByteW-1:0] byte_o
);
  import cfr_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ rtl/core/cfr_parser.sv @@
// ----------------------------------------------------------------------------
// cfr_parser
// Frame state machine with checksum, payload indexing and result register.
// ----------------------------------------------------------------------------
module cfr_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [cfr_pkg::ByteW-1:0] byte_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output cfr_pkg::result_t          result_o
);
  import cfr_pkg::*;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  sum_add;
  logic [CountW-1:0] cnt_inc;
  logic              take;
  logic              emit;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  assign take    = valid_i && (!res_valid_q || ready_i);
  assign ready_o = !res_valid_q || ready_i;
  assign sum_add = sum_q + byte_i;
  assign cnt_inc = cnt_q + CountW'(1);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    emit    = 1'b0;
    res_d.kind      = KIND_DATA;
    res_d.command   = cmd_q;
    res_d.value     = len_q;
    res_d.position  = '0;
    res_d.frame_end = 1'b1;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == StartByte) begin
          sum_d   = byte_i;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_d   = byte_i;
        sum_d   = sum_add;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = byte_i;
        sum_d = sum_add;
        cnt_d = '0;
        if (byte_i > MaxLen) begin
          phase_d     = PH_HUNT;
          emit        = 1'b1;
          res_d.kind  = KIND_BADLEN;
          res_d.value = byte_i;
        end else if (byte_i == '0) begin
          phase_d = PH_CHECK;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        emit            = 1'b1;
        res_d.kind      = KIND_DATA;
        res_d.value     = byte_i;
        res_d.position  = cnt_q[PosW-1:0];
        res_d.frame_end = 1'b0;
        sum_d           = sum_add;
        cnt_d           = cnt_inc;
        if (ByteW'(cnt_inc) >= len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        sum_d   = sum_add;
        emit    = 1'b1;
        phase_d = PH_HUNT;
        if (sum_add != '0) begin
          res_d.kind = KIND_BADSUM;
        end else if (!known_command(cmd_q)) begin
          res_d.kind = KIND_BADCMD;
        end else begin
          res_d.kind = KIND_OK;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q && !ready_i;
    if (take) begin
      res_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      cmd_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

  a_badlen_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (phase_q == PH_LEN) && (byte_i > MaxLen) |=> (phase_q == PH_HUNT))
    else $error("length error did not return to hunt");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (ByteW'(cnt_q) < len_q))
    else $error("payload count reached length in data phase");

  a_check_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (phase_q == PH_CHECK) |=> res_valid_q && res_q.frame_end)
    else $error("checksum byte gave no verdict");

  a_hunt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (phase_q == PH_HUNT) && ready_i |=> !res_valid_q)
    else $error("result produced while hunting");

endmodule

@@ rtl/core/command_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver_core
// Receives '!'-framed command frames byte by byte, checks length, checksum and
// command, forwards payload bytes and reports one verdict per frame.
// ----------------------------------------------------------------------------
// channel  dir  payload                                   beat
// rx_i     in   rx_byte[7:0]                              one received byte
// res_o    out  kind, command, value, position, frame_end one result
//
// One beat per cycle in while res_o does not stall; each byte is held in the
// input register and is parsed into the result register as it advances.
// A result shows on res_o after the input and result registers; stray, start,
// command and length bytes (except a length error) produce no result.
// A stalled result holds the parser, also for bytes that give no result;
// the input register takes one more beat only while it is empty.
// Reset returns the parser to hunting with all frame state cleared.
// ----------------------------------------------------------------------------
module command_frame_receiver_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfr_byte_if.sink     rx_i,
  cfr_result_if.source res_o
);
  import cfr_pkg::*;

  logic             pv_valid;
  logic             pv_ready;
  logic [ByteW-1:0] pv_byte;
  result_t          result;

  cfr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .ready_o (rx_i.ready),
    .byte_i  (rx_i.rx_byte),
    .valid_o (pv_valid),
    .ready_i (pv_ready),
    .byte_o  (pv_byte)
  );

  cfr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pv_valid),
    .ready_o  (pv_ready),
    .byte_i   (pv_byte),
    .valid_o  (res_o.valid),
    .ready_i  (res_o.ready),
    .result_o (result)
  );

  assign res_o.kind      = result.kind;
  assign res_o.command   = result.command;
  assign res_o.value     = result.value;
  assign res_o.position  = result.position;
  assign res_o.frame_end = result.frame_end;

endmodule

@@ dv/command_frame_receiver_checker.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver_checker
// Watches the byte and result channels of the frame receiver. It keeps its
// own parser state, turns every accepted byte beat into the result it should
// cause, and compares each accepted result beat, field by field, with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module command_frame_receiver_checker
  import cfr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  cfr_byte_if   rx_i,
  cfr_result_if res_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    payload_beats_o,
  output int    verdict_beats_o
);

  phase_e           frame_phase;
  logic [ByteW-1:0] frame_cmd;
  logic [ByteW-1:0] frame_len;
  logic [6:0]       payload_count;
  logic [ByteW-1:0] frame_sum;
  result_t          expected_results[$];

  function automatic logic is_known_cmd(input logic [ByteW-1:0] c);
    case (c)
      "V", "C", "G", "S", "I", "H", "M": return 1'b1;
      default:                           return 1'b0;
    endcase
  endfunction

  function automatic result_t beat_result(input kind_e k, input logic [ByteW-1:0] v,
                                          input logic [PosW-1:0] pos, input logic last);
    result_t r;
    r.kind      = k;
    r.command   = frame_cmd;
    r.value     = v;
    r.position  = pos;
    r.frame_end = last;
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [ByteW-1:0] b);
    kind_e verdict;
    case (frame_phase)
      PH_HUNT: begin
        if (b == StartByte) begin
          frame_sum   = b;
          frame_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_cmd   = b;
        frame_sum   = frame_sum + b;
        frame_phase = PH_LEN;
      end
      PH_LEN: begin
        frame_len     = b;
        frame_sum     = frame_sum + b;
        payload_count = '0;
        if (b > MaxLen) begin
          expected_results.push_back(beat_result(KIND_BADLEN, b, '0, 1'b1));
          frame_phase = PH_HUNT;
        end else begin
          frame_phase = (b == 0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        expected_results.push_back(beat_result(KIND_DATA, b, payload_count[PosW-1:0], 1'b0));
        frame_sum     = frame_sum + b;
        payload_count = payload_count + 1'b1;
        if (payload_count >= frame_len) frame_phase = PH_CHECK;
      end
      PH_CHECK: begin
        frame_sum = frame_sum + b;
        if (frame_sum != 0) verdict = KIND_BADSUM;
        else if (!is_known_cmd(frame_cmd)) verdict = KIND_BADCMD;
        else verdict = KIND_OK;
        expected_results.push_back(beat_result(verdict, frame_len, '0, 1'b1));
        frame_phase = PH_HUNT;
      end
      default: frame_phase = PH_HUNT;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      frame_phase   = PH_HUNT;
      frame_cmd     = '0;
      frame_len     = '0;
      payload_count = '0;
      frame_sum     = '0;
      expected_results.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      payload_beats_o = 0;
      verdict_beats_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result: kind=%0d cmd=%h value=%h pos=%0d end=%b",
                     res_i.kind, res_i.command, res_i.value, res_i.position,
                     res_i.frame_end);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_i.kind !== exp_r.kind || res_i.command !== exp_r.command ||
              res_i.value !== exp_r.value || res_i.position !== exp_r.position ||
              res_i.frame_end !== exp_r.frame_end) begin
            if (fail_count_o < 10)
              $display({"result mismatch: expected kind=%0d cmd=%h value=%h pos=%0d end=%b,",
                        " got kind=%0d cmd=%h value=%h pos=%0d end=%b"},
                       exp_r.kind, exp_r.command, exp_r.value, exp_r.position,
                       exp_r.frame_end, res_i.kind, res_i.command, res_i.value,
                       res_i.position, res_i.frame_end);
            fail_count_o++;
          end
          if (exp_r.frame_end) verdict_beats_o++;
          else payload_beats_o++;
        end
      end
      if (rx_i.valid && rx_i.ready) parse_rx_byte(rx_i.rx_byte);
      pending_o = expected_results.size();
    end
  end

endmodule

@@ dv/command_frame_receiver_core_tb.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver_core_tb
// Feeds the frame receiver with directed and random frames (good, bad
// checksum, unknown command, oversize length, truncated, line noise) under
// four idle/stall mixes, and reports the verdict of the checker beside it.
// ----------------------------------------------------------------------------
module command_frame_receiver_core_tb;
  import cfr_pkg::*;

  localparam int ItemTarget = 850;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfr_byte_if   byte_ch ();
  cfr_result_if res_ch ();

  int fail_count;
  int pending;
  int payload_beats;
  int verdict_beats;
  int idle_pct;
  int stall_pct;
  int frame_beats;
  int noise_beats;

  logic [ByteW-1:0] known_cmds [7] = '{"V", "C", "G", "S", "I", "H", "M"};

  command_frame_receiver_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (byte_ch),
    .res_o  (res_ch)
  );

  command_frame_receiver_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_i            (byte_ch),
    .res_i           (res_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .payload_beats_o (payload_beats),
    .verdict_beats_o (verdict_beats)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #400000;
    $display("command_frame_receiver_core_tb failed");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_seq(input logic [ByteW-1:0] seq[$], input bit counted);
    foreach (seq[i]) send_byte(seq[i]);
    if (counted) frame_beats += seq.size();
    else noise_beats += seq.size();
  endtask

  task automatic send_frame(input logic [ByteW-1:0] seq[$], input bit corrupt);
    logic [ByteW-1:0] sum;
    sum = '0;
    foreach (seq[i]) sum = sum + seq[i];
    sum = -sum;
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    seq.push_back(sum);
    send_seq(seq, 1'b1);
  endtask

  task automatic send_random_frame(input bit force_max);
    logic [ByteW-1:0] seq[$];
    logic [ByteW-1:0] cmd;
    int pick;
    int len;
    int r;
    pick = force_max ? 99 : $urandom_range(99);
    cmd  = ($urandom_range(99) < 85) ? known_cmds[$urandom_range(6)] : 8'($urandom);
    r    = $urandom_range(99);
    if (force_max || r >= 95) len = MaxPayload;
    else if (r < 70) len = $urandom_range(8);
    else len = $urandom_range(9, MaxPayload - 1);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
      send_seq(seq, 1'b0);
    end else if (pick < 14) begin
      seq = '{StartByte, cmd, 8'(len)};
      if (len > 0) repeat ($urandom_range(len - 1)) seq.push_back(8'($urandom));
      send_seq(seq, 1'b1);
    end else if (pick < 20) begin
      seq = '{StartByte, cmd, 8'($urandom_range(MaxPayload + 1, 255))};
      send_seq(seq, 1'b1);
    end else begin
      seq = '{StartByte, cmd, 8'(len)};
      repeat (len) seq.push_back(8'($urandom));
      send_frame(seq, $urandom_range(99) < 15);
    end
  endtask

  initial begin
    int guard;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    res_ch.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    frame_beats     = 0;
    noise_beats     = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_seq('{8'h00, 8'hFF}, 1'b0);
    send_frame('{StartByte, "V", 8'd0}, 1'b0);
    send_frame('{StartByte, "M", 8'd1, 8'hFF}, 1'b0);
    send_seq('{StartByte, "G", 8'(MaxPayload + 1)}, 1'b1);
    send_seq('{StartByte, "S", 8'hFF}, 1'b1);
    send_frame('{StartByte, 8'h00, 8'd0}, 1'b0);
    send_frame('{StartByte, "Z", 8'd0}, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 69; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      send_random_frame(p == 0);
      while (frame_beats < (p + 1) * ItemTarget / 4) send_random_frame(1'b0);
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
      while (pending != 0) @(negedge clk_i);
    end

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);

    $display("sent %0d frame bytes and %0d noise bytes over four idle/stall mixes",
             frame_beats, noise_beats);
    $display("checked %0d payload beats and %0d frame verdicts", payload_beats,
             verdict_beats);
    if (fail_count == 0 && pending == 0) begin
      $display("command_frame_receiver_core_tb passed");
    end else begin
      $display("command_frame_receiver_core_tb failed");
    end
    $finish;
  end

endmodule
